// ===== sv/sbaa_pkg.sv =====
// ----------------------------------------------------------------------------
// sbaa_pkg: shared types and codes of the sensor block averager
// Queue entry layout, push bundle, and opcode, kind and register codes.
// ----------------------------------------------------------------------------
package sbaa_pkg;

    // Report request queue geometry
    localparam int QDEPTH   = 8;
    localparam int QPTR_W   = 3;
    localparam int QCNT_W   = 4;
    localparam int MAX_PUSH = 3;

    // Node roles
    localparam logic [1:0] ROLE_PUMP1   = 2'd0;
    localparam logic [1:0] ROLE_PUMP2   = 2'd1;
    localparam logic [1:0] ROLE_CONSUME = 2'd2;

    // Input opcodes
    localparam logic OP_SAMPLE    = 1'b0;
    localparam logic OP_BATCH_END = 1'b1;

    // Sensor kinds
    localparam logic [2:0] KIND_TEMP    = 3'd0;
    localparam logic [2:0] KIND_SOIL    = 3'd2;
    localparam logic [2:0] KIND_CURRENT = 3'd4;
    localparam logic [2:0] KIND_WATER   = 3'd5;

    // Water meter select code that is ignored (and above)
    localparam logic [1:0] METER_IGNORED = 2'd2;

    // Report kinds
    localparam logic [2:0] RPT_EMERGENCY = 3'd0;
    localparam logic [2:0] RPT_TEMP_AVG  = 3'd1;
    localparam logic [2:0] RPT_CURRENT   = 3'd5;
    localparam logic [2:0] RPT_WATER1    = 3'd6;
    localparam logic [2:0] RPT_WATER2    = 3'd7;

    // Pump tags
    localparam logic [1:0] TAG_NONE  = 2'd0;
    localparam logic [1:0] TAG_PUMP1 = 2'd1;
    localparam logic [1:0] TAG_PUMP2 = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_NODE_ROLE  = 2'd0;
    localparam logic [1:0] CFG_EMERGENCY  = 2'd1;
    localparam logic [1:0] CFG_SOIL_DRY   = 2'd2;
    localparam logic [1:0] CFG_PERIOD     = 2'd3;

    // One report request; is_avg marks a raw block sum still to be divided
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [1:0]  tag;
        logic        start;
        logic        last;
        logic        is_avg;
    } t_entry;

    // Requests raised by one accepted item, entries 0 .. count-1 valid
    typedef struct packed {
        logic [1:0]       count;
        t_entry [2:0]     ent;
    } t_push;

endpackage

// ===== sv/sbaa_front.sv =====
// ----------------------------------------------------------------------------
// sbaa_front: item classifier and state keeper
// Holds configuration, channel sums and counts, consumption totals and the
// report timer; turns each accepted item into up to three report requests.
// ----------------------------------------------------------------------------
module sbaa_front #(
    parameter int BLOCK_SAMPLES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_accept,
    input  logic                 i_opcode,
    input  logic [2:0]           i_sensor_kind,
    input  logic [1:0]           i_meter_select,
    input  logic signed [15:0]   i_sample_value,
    input  logic [31:0]          i_now_ms,
    output sbaa_pkg::t_push      o_push
);

    localparam int SUM_W = 16 + $clog2(BLOCK_SAMPLES);
    localparam int CNT_W = $clog2(BLOCK_SAMPLES + 1);

    // Add a sample into a total, clamping at the signed 32-bit limits
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [15:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

    logic [1:0]               r_node_role, n_node_role;
    logic signed [15:0]       r_emergency_level, n_emergency_level;
    logic signed [15:0]       r_soil_dry_level, n_soil_dry_level;
    logic [31:0]              r_report_period, n_report_period;
    logic signed [SUM_W-1:0]  r_sum [4];
    logic signed [SUM_W-1:0]  n_sum [4];
    logic [CNT_W-1:0]         r_cnt [4];
    logic [CNT_W-1:0]         n_cnt [4];
    logic signed [31:0]       r_total [3];
    logic signed [31:0]       n_total [3];
    logic [31:0]              r_last_time, n_last_time;

    logic [1:0]               w_chan;
    logic signed [SUM_W-1:0]  w_sum_add;
    logic [CNT_W-1:0]         w_cnt_inc;
    logic                     w_block_done;
    logic [31:0]              w_elapsed;
    logic                     w_due;
    sbaa_pkg::t_push          w_push;

    assign w_chan       = i_sensor_kind[1:0];
    assign w_sum_add    = r_sum[w_chan] + SUM_W'(i_sample_value);
    assign w_cnt_inc    = r_cnt[w_chan] + 1'b1;
    assign w_block_done = (w_cnt_inc >= CNT_W'(BLOCK_SAMPLES));
    assign w_elapsed    = i_now_ms - r_last_time;
    assign w_due        = (w_elapsed >= r_report_period);

    // Classify the item, update state and raise report requests
    always_comb begin
        n_node_role       = r_node_role;
        n_emergency_level = r_emergency_level;
        n_soil_dry_level  = r_soil_dry_level;
        n_report_period   = r_report_period;
        n_sum             = r_sum;
        n_cnt             = r_cnt;
        n_total           = r_total;
        n_last_time       = r_last_time;
        w_push            = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                sbaa_pkg::CFG_NODE_ROLE: n_node_role       = i_cfg_data[1:0];
                sbaa_pkg::CFG_EMERGENCY: n_emergency_level = i_cfg_data[15:0];
                sbaa_pkg::CFG_SOIL_DRY:  n_soil_dry_level  = i_cfg_data[15:0];
                sbaa_pkg::CFG_PERIOD:    n_report_period   = i_cfg_data;
                default:                 n_node_role       = r_node_role;
            endcase
        end

        if (i_accept) begin
            if (r_node_role == sbaa_pkg::ROLE_CONSUME) begin
                if (i_opcode == sbaa_pkg::OP_SAMPLE) begin
                    // Add into the running totals
                    if (i_sensor_kind == sbaa_pkg::KIND_CURRENT) begin
                        n_total[0] = sat_add(r_total[0], i_sample_value);
                    end else if (i_sensor_kind == sbaa_pkg::KIND_WATER &&
                                 i_meter_select < sbaa_pkg::METER_IGNORED) begin
                        if (i_meter_select[0]) begin
                            n_total[2] = sat_add(r_total[2], i_sample_value);
                        end else begin
                            n_total[1] = sat_add(r_total[1], i_sample_value);
                        end
                    end
                end else if (w_due) begin
                    // Report all three totals and restart the period
                    w_push.count         = 2'd3;
                    w_push.ent[0].kind   = sbaa_pkg::RPT_CURRENT;
                    w_push.ent[0].value  = r_total[0];
                    w_push.ent[1].kind   = sbaa_pkg::RPT_WATER1;
                    w_push.ent[1].value  = r_total[1];
                    w_push.ent[2].kind   = sbaa_pkg::RPT_WATER2;
                    w_push.ent[2].value  = r_total[2];
                    n_last_time          = i_now_ms;
                end
            end else if (i_opcode == sbaa_pkg::OP_SAMPLE && !i_sensor_kind[2]) begin
                // Emergency report goes ahead of any average
                if (i_sensor_kind == sbaa_pkg::KIND_TEMP &&
                    i_sample_value >= r_emergency_level) begin
                    w_push.ent[0].kind  = sbaa_pkg::RPT_EMERGENCY;
                    w_push.ent[0].value = 32'(i_sample_value);
                    w_push.count        = 2'd1;
                end
                n_sum[w_chan] = w_sum_add;
                n_cnt[w_chan] = w_cnt_inc;
                if (w_block_done) begin
                    w_push.ent[w_push.count].kind   = 3'(w_chan) + sbaa_pkg::RPT_TEMP_AVG;
                    w_push.ent[w_push.count].value  = 32'(w_sum_add);
                    w_push.ent[w_push.count].is_avg = 1'b1;
                    if (i_sensor_kind == sbaa_pkg::KIND_SOIL &&
                        i_sample_value <= r_soil_dry_level) begin
                        w_push.ent[w_push.count].start = 1'b1;
                        case (r_node_role)
                            sbaa_pkg::ROLE_PUMP1: w_push.ent[w_push.count].tag =
                                                      sbaa_pkg::TAG_PUMP1;
                            sbaa_pkg::ROLE_PUMP2: w_push.ent[w_push.count].tag =
                                                      sbaa_pkg::TAG_PUMP2;
                            default:              w_push.ent[w_push.count].tag =
                                                      sbaa_pkg::TAG_NONE;
                        endcase
                    end
                    w_push.count  = w_push.count + 2'd1;
                    n_sum[w_chan] = '0;
                    n_cnt[w_chan] = '0;
                end
            end
        end

        // Mark the final request of this item
        if (w_push.count != 2'd0) begin
            w_push.ent[w_push.count - 2'd1].last = 1'b1;
        end
    end

    assign o_push = w_push;

    // Hold configuration and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_role       <= sbaa_pkg::ROLE_PUMP1;
            r_emergency_level <= 16'sd800;
            r_soil_dry_level  <= 16'sd480;
            r_report_period   <= 32'd3600000;
            for (int i = 0; i < 4; i++) begin
                r_sum[i] <= '0;
                r_cnt[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_total[i] <= '0;
            end
            r_last_time       <= '0;
        end else begin
            r_node_role       <= n_node_role;
            r_emergency_level <= n_emergency_level;
            r_soil_dry_level  <= n_soil_dry_level;
            r_report_period   <= n_report_period;
            r_sum             <= n_sum;
            r_cnt             <= n_cnt;
            r_total           <= n_total;
            r_last_time       <= n_last_time;
        end
    end

endmodule

// ===== sv/sbaa_queue.sv =====
// ----------------------------------------------------------------------------
// sbaa_queue: report request queue
// Takes up to three requests a cycle from the front, hands one a cycle to the
// back as it pops; signals space while three more requests still fit.
// ----------------------------------------------------------------------------
module sbaa_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sbaa_pkg::t_push   i_push,
    input  logic              i_pop,
    output sbaa_pkg::t_entry  o_head,
    output logic              o_nonempty,
    output logic              o_space
);

    sbaa_pkg::t_entry                r_mem [sbaa_pkg::QDEPTH];
    logic [sbaa_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [sbaa_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [sbaa_pkg::QCNT_W-1:0]     r_count, n_count;

    assign o_head     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_count != '0);
    assign o_space    = (r_count <=
                         sbaa_pkg::QCNT_W'(sbaa_pkg::QDEPTH - sbaa_pkg::MAX_PUSH));

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr + sbaa_pkg::QPTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + sbaa_pkg::QPTR_W'(i_pop);
        n_count  = r_count + sbaa_pkg::QCNT_W'(i_push.count)
                           - sbaa_pkg::QCNT_W'(i_pop);
    end

    // Store incoming requests
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < sbaa_pkg::MAX_PUSH; j++) begin
            if (2'(j) < i_push.count) begin
                r_mem[r_wr_ptr + sbaa_pkg::QPTR_W'(j)] <= i_push.ent[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sbaa_pkg::QCNT_W'(sbaa_pkg::QDEPTH))
        else $error("queue fill count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("empty queue with unequal pointers");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |->
            (r_count + sbaa_pkg::QCNT_W'(i_push.count) <=
             sbaa_pkg::QCNT_W'(sbaa_pkg::QDEPTH)))
        else $error("push overflows queue");

endmodule

// ===== sv/sbaa_back.sv =====
// ----------------------------------------------------------------------------
// sbaa_back: report output stage
// Pops one request a cycle when not stalled, divides block sums by block
// length via a reciprocal multiply, holds the result in the output register.
// ----------------------------------------------------------------------------
module sbaa_back #(
    parameter int BLOCK_SAMPLES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbaa_pkg::t_entry   i_head,
    input  logic               i_nonempty,
    input  logic               i_out_stall,
    output logic               o_pop,
    output logic               o_out_valid,
    output logic [2:0]         o_report_kind,
    output logic signed [31:0] o_report_value,
    output logic [1:0]         o_pump_tag,
    output logic               o_pump_start,
    output logic               o_last_of_run
);

    localparam int SUM_W  = 16 + $clog2(BLOCK_SAMPLES);
    localparam int REC_SH = SUM_W + $clog2(BLOCK_SAMPLES) + 1;
    localparam int PROD_W = SUM_W + REC_SH + 1;
    localparam longint unsigned REC_FULL =
        ((64'd1 << REC_SH) + 64'(BLOCK_SAMPLES) - 64'd1) / 64'(BLOCK_SAMPLES);
    localparam logic [REC_SH:0] REC = (REC_SH + 1)'(REC_FULL);

    logic                     r_out_valid;
    logic [2:0]               r_kind;
    logic signed [31:0]       r_value;
    logic [1:0]               r_tag;
    logic                     r_start;
    logic                     r_last;

    logic                     w_load;
    logic signed [SUM_W-1:0]  w_sum;
    logic                     w_neg;
    logic [SUM_W-1:0]         w_mag;
    logic [PROD_W-1:0]        w_prod;
    logic [SUM_W-1:0]         w_quot;
    logic signed [SUM_W-1:0]  w_avg;
    logic signed [31:0]       w_value;

    assign w_load = i_nonempty && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_load;

    // Divide the block sum, truncating toward zero
    always_comb begin
        w_sum   = i_head.value[SUM_W-1:0];
        w_neg   = w_sum[SUM_W-1];
        w_mag   = w_neg ? SUM_W'(-w_sum) : SUM_W'(w_sum);
        w_prod  = PROD_W'(w_mag) * PROD_W'(REC);
        w_quot  = w_prod[REC_SH +: SUM_W];
        w_avg   = w_neg ? -$signed(w_quot) : $signed(w_quot);
        w_value = i_head.is_avg ? 32'(w_avg) : i_head.value;
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind  <= i_head.kind;
            r_value <= w_value;
            r_tag   <= i_head.tag;
            r_start <= i_head.start;
            r_last  <= i_head.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_report_kind  = r_kind;
    assign o_report_value = r_value;
    assign o_pump_tag     = r_tag;
    assign o_pump_start   = r_start;
    assign o_last_of_run  = r_last;

endmodule

// ===== sv/sensor_block_average_alarm.sv =====
// ----------------------------------------------------------------------------
// sensor_block_average_alarm: sensor block averager with alarms and totals
// Plant mode: per-channel block averages, emergency and pump reports.
// Consumption mode: saturating totals reported at the end of each period.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall    | opcode, kind, meter, sample,
//           |           |                            | now_ms
//   out     | output    | o_out_valid / i_out_stall  | kind, value, pump tag,
//           |           |                            | pump start, last of run
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | index, data
//
// One item is taken per cycle while the eight-entry request queue has room
// for three more requests; its first report goes through the queue and then
// the output register, and reports drain one per cycle while not stalled.
// Reset is synchronous; no clearing pass.
// A stalled output holds its report; the queue then fills and stalls input.
// ----------------------------------------------------------------------------
module sensor_block_average_alarm #(
    parameter int BLOCK_SAMPLES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic [2:0]         i_sensor_kind,
    input  logic [1:0]         i_meter_select,
    input  logic signed [15:0] i_sample_value,
    input  logic [31:0]        i_now_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_report_kind,
    output logic signed [31:0] o_report_value,
    output logic [1:0]         o_pump_tag,
    output logic               o_pump_start,
    output logic               o_last_of_run
);

    sbaa_pkg::t_push   w_push;
    sbaa_pkg::t_entry  w_head;
    logic              w_nonempty;
    logic              w_space;
    logic              w_pop;
    logic              w_accept;

    // Accept a request while the queue has room for its reports
    assign o_in_stall  = !w_space;
    assign w_accept    = i_in_valid && w_space;
    assign o_cfg_ready = 1'b1;

    sbaa_front #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (w_accept),
        .i_opcode       (i_opcode),
        .i_sensor_kind  (i_sensor_kind),
        .i_meter_select (i_meter_select),
        .i_sample_value (i_sample_value),
        .i_now_ms       (i_now_ms),
        .o_push         (w_push)
    );

    sbaa_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_nonempty (w_nonempty),
        .o_space    (w_space)
    );

    sbaa_back #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_nonempty     (w_nonempty),
        .i_out_stall    (i_out_stall),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .o_report_kind  (o_report_kind),
        .o_report_value (o_report_value),
        .o_pump_tag     (o_pump_tag),
        .o_pump_start   (o_pump_start),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ===== dv/sensor_block_average_alarm_test.sv =====
// ----------------------------------------------------------------------------
// sensor_block_average_alarm_test: self-checking bench for the block averager
// Drives sample and batch-end requests with random gaps and output stalls,
// predicts every report from its own model of the channels and totals, and
// compares each report field by field, in order.
// ----------------------------------------------------------------------------
module sensor_block_average_alarm_test;

    localparam int BLOCK_SAMPLES = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALE_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 60;

    // Codes the package leaves unnamed
    localparam logic [2:0] KIND_AIR    = 3'd1;
    localparam logic [2:0] KIND_LIGHT  = 3'd3;
    localparam logic [2:0] KIND_OTHER  = 3'd6;
    localparam logic [2:0] KIND_SPARE  = 3'd7;
    localparam logic [1:0] ROLE_SPARE  = 2'd3;
    localparam logic [1:0] METER_ONE   = 2'd0;
    localparam logic [1:0] METER_TWO   = 2'd1;
    localparam logic [1:0] METER_SPARE = 2'd3;

    typedef struct packed {
        logic               op;
        logic [2:0]         kind;
        logic [1:0]         meter;
        logic signed [15:0] value;
        logic [31:0]        stamp;
    } t_sensor_req;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [1:0]         tag;
        logic               start;
        logic               last;
    } t_report;

    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index    = sbaa_pkg::CFG_NODE_ROLE;
    logic [31:0]        i_cfg_data     = '0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic               i_opcode       = sbaa_pkg::OP_SAMPLE;
    logic [2:0]         i_sensor_kind  = sbaa_pkg::KIND_TEMP;
    logic [1:0]         i_meter_select = METER_ONE;
    logic signed [15:0] i_sample_value = '0;
    logic [31:0]        i_now_ms       = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic [2:0]         o_report_kind;
    logic signed [31:0] o_report_value;
    logic [1:0]         o_pump_tag;
    logic               o_pump_start;
    logic               o_last_of_run;

    sensor_block_average_alarm #(
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_sensor_kind  (i_sensor_kind),
        .i_meter_select (i_meter_select),
        .i_sample_value (i_sample_value),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_report_kind  (o_report_kind),
        .o_report_value (o_report_value),
        .o_pump_tag     (o_pump_tag),
        .o_pump_start   (o_pump_start),
        .o_last_of_run  (o_last_of_run)
    );

    // Predicted configuration, updated on each accepted register write
    logic [1:0]         cfg_role   = sbaa_pkg::ROLE_PUMP1;
    logic signed [15:0] cfg_emerg  = 16'sd800;
    logic signed [15:0] cfg_soil   = 16'sd480;
    logic [31:0]        cfg_period = 32'd3600000;

    // Predicted block state
    logic signed [22:0] chan_sum   [4];
    logic [6:0]         chan_count [4];
    logic signed [31:0] meter_total [3];
    logic [31:0]        last_report_ms = '0;

    t_report            pending_reports[$];

    // Bench bookkeeping
    int   mismatch_count = 0;
    int   stale_cycles   = 0;
    int   hold_left      = 0;
    int   stall_left     = 0;
    int   free_left      = 0;
    bit   idle_on        = 1'b1;

    // Stimulus-side view of the settings, used to aim requests at boundaries
    logic [1:0]         plan_role   = sbaa_pkg::ROLE_PUMP1;
    logic signed [15:0] plan_emerg  = 16'sd800;
    logic signed [15:0] plan_soil   = 16'sd480;
    logic [31:0]        plan_period = 32'd3600000;
    logic [31:0]        plan_last   = '0;

    initial begin
        for (int i = 0; i < 4; i++) begin
            chan_sum[i]   = '0;
            chan_count[i] = '0;
        end
        for (int i = 0; i < 3; i++) meter_total[i] = '0;
    end

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] sat_add32(logic signed [31:0] acc,
                                                     logic signed [15:0] inc);
        longint s;
        s = longint'(acc) + longint'(inc);
        if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (s < -64'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic void predict_reports(t_sensor_req r);
        t_report            batch[3];
        int                 n;
        logic [31:0]        elapsed;
        logic signed [31:0] avg;
        n = 0;
        if (cfg_role == sbaa_pkg::ROLE_CONSUME) begin
            if (r.op == sbaa_pkg::OP_SAMPLE) begin
                if (r.kind == sbaa_pkg::KIND_CURRENT)
                    meter_total[0] = sat_add32(meter_total[0], r.value);
                else if (r.kind == sbaa_pkg::KIND_WATER &&
                         r.meter < sbaa_pkg::METER_IGNORED)
                    meter_total[1 + r.meter] =
                        sat_add32(meter_total[1 + r.meter], r.value);
            end else begin
                elapsed = r.stamp - last_report_ms;
                if (elapsed >= cfg_period) begin
                    batch[0] = '{sbaa_pkg::RPT_CURRENT, meter_total[0],
                                 sbaa_pkg::TAG_NONE, 1'b0, 1'b0};
                    batch[1] = '{sbaa_pkg::RPT_WATER1,  meter_total[1],
                                 sbaa_pkg::TAG_NONE, 1'b0, 1'b0};
                    batch[2] = '{sbaa_pkg::RPT_WATER2,  meter_total[2],
                                 sbaa_pkg::TAG_NONE, 1'b0, 1'b0};
                    n = 3;
                    last_report_ms = r.stamp;
                end
            end
        end else if (r.op == sbaa_pkg::OP_SAMPLE && r.kind < sbaa_pkg::KIND_CURRENT) begin
            // Emergency goes out ahead of any block average
            if (r.kind == sbaa_pkg::KIND_TEMP && r.value >= cfg_emerg) begin
                batch[n] = '{sbaa_pkg::RPT_EMERGENCY, 32'(r.value),
                             sbaa_pkg::TAG_NONE, 1'b0, 1'b0};
                n++;
            end
            chan_sum[r.kind]   = chan_sum[r.kind] + 23'(r.value);
            chan_count[r.kind] = chan_count[r.kind] + 7'd1;
            if (chan_count[r.kind] >= 7'(BLOCK_SAMPLES)) begin
                avg = 32'(chan_sum[r.kind]) / BLOCK_SAMPLES;
                batch[n] = '{3'(sbaa_pkg::RPT_TEMP_AVG + r.kind), avg,
                             sbaa_pkg::TAG_NONE, 1'b0, 1'b0};
                if (r.kind == sbaa_pkg::KIND_SOIL && r.value <= cfg_soil) begin
                    batch[n].start = 1'b1;
                    batch[n].tag   = (cfg_role == sbaa_pkg::ROLE_PUMP1) ?
                                     sbaa_pkg::TAG_PUMP1 :
                                     (cfg_role == sbaa_pkg::ROLE_PUMP2) ?
                                     sbaa_pkg::TAG_PUMP2 : sbaa_pkg::TAG_NONE;
                end
                n++;
                chan_sum[r.kind]   = '0;
                chan_count[r.kind] = '0;
            end
        end
        for (int i = 0; i < n; i++) begin
            batch[i].last = (i == n - 1);
            pending_reports.push_back(batch[i]);
        end
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [31:0] data);
        case (idx)
            sbaa_pkg::CFG_NODE_ROLE: cfg_role   = data[1:0];
            sbaa_pkg::CFG_EMERGENCY: cfg_emerg  = data[15:0];
            sbaa_pkg::CFG_SOIL_DRY:  cfg_soil   = data[15:0];
            sbaa_pkg::CFG_PERIOD:    cfg_period = data;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] report %s mismatch: got %h want %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: check the report leaving, then predict from the request taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_report got;
        t_report want;
        if (i_rst_n) begin
            stale_cycles++;
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                stale_cycles = 0;
                got = '{o_report_kind, o_report_value, o_pump_tag, o_pump_start,
                        o_last_of_run};
                if (pending_reports.size() == 0) begin
                    report_mismatch("unexpected", 32'(got.kind), 32'hFFFFFFFF);
                end else begin
                    want = pending_reports.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                    if (got.value !== want.value)
                        report_mismatch("value", got.value, want.value);
                    if (got.tag !== want.tag)
                        report_mismatch("pump_tag", 32'(got.tag), 32'(want.tag));
                    if (got.start !== want.start)
                        report_mismatch("pump_start", 32'(got.start), 32'(want.start));
                    if (got.last !== want.last)
                        report_mismatch("last_of_run", 32'(got.last), 32'(want.last));
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                stale_cycles = 0;
                predict_reports('{i_opcode, i_sensor_kind, i_meter_select, i_sample_value,
                                  i_now_ms});
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                stale_cycles = 0;
                apply_register(i_cfg_index, i_cfg_data);
            end
        end
    end

    // Receiver: random stall bursts, free stretches, and a counted long hold
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (free_left > 0) begin
            i_out_stall <= 1'b0;
            free_left--;
        end else if (idle_on && $urandom_range(0, 2) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(1, 9) - 1;
        end else begin
            i_out_stall <= 1'b0;
            free_left = $urandom_range(0, 20);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        while (stale_cycles < STALE_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------
    // Offer one request; valid is left high so a following request follows on
    task automatic send_req(input t_sensor_req r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= r.op;
        i_sensor_kind  <= r.kind;
        i_meter_select <= r.meter;
        i_sample_value <= r.value;
        i_now_ms       <= r.stamp;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        // Track the period start so later batch ends can aim at its boundary
        if (plan_role == sbaa_pkg::ROLE_CONSUME && r.op == sbaa_pkg::OP_BATCH_END &&
            r.stamp - plan_last >= plan_period)
            plan_last = r.stamp;
    endtask

    // Drop valid and hold until every predicted report has come out
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers; unused upper data bits carry noise
    task automatic set_config(input logic [1:0] role, input logic signed [15:0] emerg,
                              input logic signed [15:0] soil, input logic [31:0] period);
        logic [31:0] data [4];
        data[sbaa_pkg::CFG_NODE_ROLE] = {30'($urandom() >> 2), role};
        data[sbaa_pkg::CFG_EMERGENCY] = {16'($urandom()), emerg};
        data[sbaa_pkg::CFG_SOIL_DRY]  = {16'($urandom()), soil};
        data[sbaa_pkg::CFG_PERIOD]    = period;
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 2'(i);
            i_cfg_data  <= data[i];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        end
        i_cfg_valid <= 1'b0;
        plan_role   = role;
        plan_emerg  = emerg;
        plan_soil   = soil;
        plan_period = period;
    endtask

    // ------------------------------------------------------------------
    // Random request shaping
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            default: return 16'($urandom_range(0, 1200));
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFFFFFF;
            3:       return $urandom();
            default: return $urandom_range(2, 40);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_value(logic signed [15:0] level);
        case ($urandom_range(0, 4))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return level + 16'($urandom_range(0, 4)) - 16'sd2;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_sensor_req random_req();
        t_sensor_req r;
        r.meter = 2'($urandom_range(0, 3));
        r.stamp = $urandom();
        if (plan_role == sbaa_pkg::ROLE_CONSUME) begin
            // Mostly meter samples and batch ends near the period boundary
            r.op   = ($urandom_range(0, 4) == 0) ? sbaa_pkg::OP_BATCH_END :
                     sbaa_pkg::OP_SAMPLE;
            r.kind = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) :
                     ($urandom_range(0, 1) == 0) ? sbaa_pkg::KIND_CURRENT :
                     sbaa_pkg::KIND_WATER;
            r.value = pick_value(16'sd0);
            if (r.op == sbaa_pkg::OP_BATCH_END) begin
                case ($urandom_range(0, 3))
                    0:       r.stamp = plan_last + plan_period;
                    1:       r.stamp = plan_last + plan_period - 32'd1;
                    2:       r.stamp = $urandom();
                    default: r.stamp = plan_last + $urandom_range(0, 64);
                endcase
            end
        end else begin
            // Mostly channel samples so blocks complete; some noise
            r.op   = ($urandom_range(0, 9) == 0) ? sbaa_pkg::OP_BATCH_END :
                     sbaa_pkg::OP_SAMPLE;
            r.kind = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7)) :
                     3'($urandom_range(0, 3));
            r.value = pick_value((r.kind == sbaa_pkg::KIND_TEMP) ? plan_emerg : plan_soil);
        end
        return r;
    endfunction

    task automatic random_phase(input logic [1:0] role, input int count);
        set_config(role, pick_level(), pick_level(), pick_period());
        repeat (count) send_req(random_req());
        wait_quiet();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Spare role: emergency at the top of the range, negative soil average,
    // dry block starts the pump untagged, batch end and foreign kinds ignored
    task automatic test_plant_blocks();
        set_config(ROLE_SPARE, 16'sh7FFF, 16'sh7FFF, 32'd1);
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_TEMP, METER_ONE, 16'sh7FFF, 32'd0});
        repeat (BLOCK_SAMPLES - 1)
            send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_SOIL, METER_ONE, 16'sh8000,
                       32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_SOIL, METER_ONE, 16'sh7FFF, 32'd0});
        send_req('{sbaa_pkg::OP_BATCH_END, sbaa_pkg::KIND_TEMP, METER_ONE, 16'sd0,
                   32'hFFFFFFFF});
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_CURRENT, METER_ONE, 16'sd100, 32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_WATER, METER_TWO, 16'sd100, 32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, KIND_OTHER, METER_ONE, 16'sd100, 32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, KIND_SPARE, METER_ONE, 16'sd100, 32'd0});
        wait_quiet();
    endtask

    // Zero period: every batch end reports; totals are kept after a report
    task automatic test_consumption_totals();
        set_config(sbaa_pkg::ROLE_CONSUME, 16'sh8000, 16'sh8000, 32'd0);
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_CURRENT, METER_ONE, 16'sh7FFF, 32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_WATER, METER_ONE, 16'sh8000, 32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_WATER, METER_TWO, 16'sd1, 32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_WATER, sbaa_pkg::METER_IGNORED,
                   16'sd5, 32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_WATER, METER_SPARE, 16'sd5, 32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, KIND_AIR, METER_ONE, 16'sd100, 32'd0});
        send_req('{sbaa_pkg::OP_BATCH_END, KIND_LIGHT, METER_ONE, 16'sd0, 32'd0});
        send_req('{sbaa_pkg::OP_BATCH_END, sbaa_pkg::KIND_TEMP, METER_ONE, 16'sd0,
                   32'hFFFFFFFF});
        wait_quiet();
    endtask

    // Hold the output for a long stretch while batch ends keep coming
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        set_config(sbaa_pkg::ROLE_CONSUME, 16'sd800, 16'sd480, 32'd0);
        hold_left = HOLD_CYCLES;
        repeat (10)
            send_req('{sbaa_pkg::OP_BATCH_END, sbaa_pkg::KIND_CURRENT, METER_ONE, 16'sd0,
                       $urandom()});
        wait_quiet();
        idle_on = 1'b1;
    endtask

    // Cycle the roles, keeping state across role changes
    task automatic test_random_traffic();
        logic [1:0] roles [4];
        roles = '{sbaa_pkg::ROLE_PUMP1, sbaa_pkg::ROLE_PUMP2, sbaa_pkg::ROLE_CONSUME,
                  ROLE_SPARE};
        for (int phase = 0; phase < 4; phase++) begin
            random_phase(roles[phase], 20);
        end
    endtask

    // Drive the totals to both signs; report before and after
    task automatic test_total_signs();
        set_config(sbaa_pkg::ROLE_CONSUME, 16'sd800, 16'sd480, 32'd0);
        repeat (3)
            send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_CURRENT, METER_ONE, 16'sh7FFF,
                       32'd0});
        repeat (3)
            send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_WATER, METER_ONE, 16'sh8000,
                       32'd0});
        send_req('{sbaa_pkg::OP_BATCH_END, sbaa_pkg::KIND_CURRENT, METER_ONE, 16'sd0,
                   32'd7});
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_CURRENT, METER_ONE, 16'sh8000, 32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_WATER, METER_ONE, 16'sd1, 32'd0});
        send_req('{sbaa_pkg::OP_SAMPLE, sbaa_pkg::KIND_WATER, METER_TWO, 16'sh8000, 32'd0});
        send_req('{sbaa_pkg::OP_BATCH_END, sbaa_pkg::KIND_CURRENT, METER_ONE, 16'sd0,
                   32'd8});
        wait_quiet();
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_steady_stream();
        random_phase(sbaa_pkg::ROLE_PUMP1, 15);
        random_phase(sbaa_pkg::ROLE_CONSUME, 15);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plant_blocks();
        test_consumption_totals();
        test_output_backpressure();
        test_random_traffic();
        idle_on = 1'b0;
        test_total_signs();
        test_steady_stream();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
